// ===== src/vcc_pkg.sv =====
// Shared types, constants and letter mapping functions for the Cyrillic Vigenere cipher.
package vcc_pkg;

  localparam int CODE_W    = 16;
  localparam int RESULT_W  = 11;
  localparam int IDX_W     = 6;
  localparam int KEY_LEN_W = 5;
  localparam int KEY_WORD_W = 48;
  localparam int CFG_IDX_W = 2;
  localparam int SLOTS_PER_WORD = 8;

  localparam logic [IDX_W-1:0] ALPHA_SIZE = 6'd33;
  localparam logic [IDX_W-1:0] IDX_YO     = 6'd6;

  localparam logic [CODE_W-1:0] CP_YO     = 16'h0401;
  localparam logic [CODE_W-1:0] CP_A      = 16'h0410;
  localparam logic [CODE_W-1:0] CP_YE     = 16'h0415;
  localparam logic [CODE_W-1:0] CP_ZHE    = 16'h0416;
  localparam logic [CODE_W-1:0] CP_YA     = 16'h042F;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH    = 2'd2;

  // One letter after decoding and key lookup, on its way to the result stage.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] key;
    logic             decrypt;
    logic             bad;
  } vcc_item_t;

  // Alphabet index of a code point; bit IDX_W is set when it is a valid letter.
  function automatic logic [IDX_W:0] code_to_index(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] diff;
    logic [IDX_W:0]    res;
    res = '0;
    diff = '0;
    if (code == CP_YO) begin
      res = {1'b1, IDX_YO};
    end else if (code >= CP_A && code <= CP_YE) begin
      diff = code - CP_A;
      res = {1'b1, diff[IDX_W-1:0]};
    end else if (code >= CP_ZHE && code <= CP_YA) begin
      diff = code - CP_ZHE + 16'd7;
      res = {1'b1, diff[IDX_W-1:0]};
    end
    return res;
  endfunction

  // Code point of an alphabet index in the range 0 to 32.
  function automatic logic [RESULT_W-1:0] index_to_code(input logic [IDX_W-1:0] idx);
    logic [RESULT_W-1:0] res;
    if (idx == IDX_YO) begin
      res = CP_YO[RESULT_W-1:0];
    end else if (idx < IDX_YO) begin
      res = CP_A[RESULT_W-1:0] + RESULT_W'(idx);
    end else begin
      res = CP_A[RESULT_W-1:0] + RESULT_W'(idx) - 11'd1;
    end
    return res;
  endfunction

endpackage

// ===== src/vcc_letter_unit.sv =====
// Modular add or subtract of the key letter and mapping back to a code point.
module vcc_letter_unit
  import vcc_pkg::*;
(
  input  vcc_item_t           item,
  output logic [RESULT_W-1:0] result_code,
  output logic                bad_letter
);

  logic [IDX_W:0]   sum;
  logic [IDX_W:0]   wrapped;
  logic [IDX_W-1:0] new_idx;

  always_comb begin
    if (item.decrypt) begin
      sum = {1'b0, item.idx} + {1'b0, ALPHA_SIZE} - {1'b0, item.key};
    end else begin
      sum = {1'b0, item.idx} + {1'b0, item.key};
    end
    // Both operands are below 33, so one conditional subtract reduces the sum.
    wrapped = (sum >= {1'b0, ALPHA_SIZE}) ? sum - {1'b0, ALPHA_SIZE} : sum;
    new_idx = wrapped[IDX_W-1:0];
    bad_letter = item.bad;
    result_code = item.bad ? '0 : index_to_code(new_idx);
  end

endmodule

// ===== src/vigenere_cyrillic_letter_cipher.sv =====
// Vigenere cipher over the 33-letter Russian uppercase alphabet, one letter per beat.
// An accepted input beat is registered in the decode stage, then in the output register.
// Throughput: one letter per cycle unless stalled; key position moves in the accept cycle.
// The decode stage and the output register advance together, so out_stall reaches in_stall.
// Synchronous active-low reset clears the stage valids and key position; key length resets
// to one and both key words to zero.
module vigenere_cyrillic_letter_cipher
  import vcc_pkg::*;
#(
  parameter int KEY_MAX = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CODE_W-1:0]     in_letter_code,
  input  logic                  in_first_of_message,
  input  logic                  in_direction,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RESULT_W-1:0]   out_result_code,
  output logic                  out_bad_letter,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [KEY_WORD_W-1:0] cfg_data
);

  localparam int POS_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

  logic [KEY_LEN_W-1:0]  key_length_r;
  logic [KEY_WORD_W-1:0] key_low_r;
  logic [KEY_WORD_W-1:0] key_high_r;
  logic [POS_W-1:0]      key_position_r;
  logic [POS_W-1:0]      key_position_nxt;

  logic                  s1_valid_r;
  vcc_item_t             s1_item_r;
  vcc_item_t             s1_item_nxt;
  logic                  out_valid_r;
  logic [RESULT_W-1:0]   out_result_code_r;
  logic                  out_bad_letter_r;
  logic [RESULT_W-1:0]   unit_code;
  logic                  unit_bad;

  logic                  in_accept;
  logic                  out_free;
  logic [KEY_LEN_W-1:0]  eff_len;
  logic [POS_W-1:0]      pos_cur;
  logic [KEY_LEN_W-1:0]  pos_inc;
  logic [IDX_W:0]        decoded;
  logic [IDX_W-1:0]      slot_raw;
  logic [IDX_W-1:0]      key_slot [KEY_MAX];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= KEY_LEN_W'(1);
      key_low_r    <= '0;
      key_high_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_LENGTH: key_length_r <= cfg_data[KEY_LEN_W-1:0];
        REG_KEY_LOW:    key_low_r    <= cfg_data;
        REG_KEY_HIGH:   key_high_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < KEY_MAX; i++) begin : g_slot
    if (i < SLOTS_PER_WORD) begin : g_low
      assign key_slot[i] = key_low_r[IDX_W*i +: IDX_W];
    end else begin : g_high
      assign key_slot[i] = key_high_r[IDX_W*(i-SLOTS_PER_WORD) +: IDX_W];
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    // A length of zero counts as one, and a length above KEY_MAX saturates.
    if (key_length_r == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_length_r > KEY_LEN_W'(KEY_MAX)) begin
      eff_len = KEY_LEN_W'(KEY_MAX);
    end else begin
      eff_len = key_length_r;
    end

    pos_cur = in_first_of_message ? '0 : key_position_r;
    if (KEY_LEN_W'(pos_cur) >= eff_len) begin
      pos_cur = '0;
    end

    decoded  = code_to_index(in_letter_code);
    slot_raw = key_slot[pos_cur];

    s1_item_nxt.idx     = decoded[IDX_W-1:0];
    s1_item_nxt.key     = (slot_raw >= ALPHA_SIZE) ? slot_raw - ALPHA_SIZE : slot_raw;
    s1_item_nxt.decrypt = in_direction;
    s1_item_nxt.bad     = !decoded[IDX_W];

    pos_inc = KEY_LEN_W'(pos_cur) + KEY_LEN_W'(1);
    if (!decoded[IDX_W]) begin
      key_position_nxt = pos_cur;
    end else if (pos_inc >= eff_len) begin
      key_position_nxt = '0;
    end else begin
      key_position_nxt = pos_inc[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_position_r <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_accept) begin
        key_position_r <= key_position_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (out_free) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= s1_item_nxt;
    end
    if (out_free && s1_valid_r) begin
      out_result_code_r <= unit_code;
      out_bad_letter_r  <= unit_bad;
    end
  end

  vcc_letter_unit u_letter (
    .item        (s1_item_r),
    .result_code (unit_code),
    .bad_letter  (unit_bad)
  );

  assign out_valid       = out_valid_r;
  assign out_result_code = out_result_code_r;
  assign out_bad_letter  = out_bad_letter_r;

  // The input side only waits when the decode stage holds a beat.
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("in_stall raised with an empty decode stage");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid_r)
    else $error("accepted beat did not reach the decode stage");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_letter) |-> (out_result_code == '0))
    else $error("bad letter carries a nonzero code");

  a_good_in_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_bad_letter) |->
      ((out_result_code == 11'h401) ||
       (out_result_code >= 11'h410 && out_result_code <= 11'h42F)))
    else $error("result code is outside the alphabet");

endmodule
